FILE: hw/rtl/byte_ring_buffer_block_push_pop_defines.svh
// Assertion macros used by the ring buffer controller RTL.
`ifndef BYTE_RING_BUFFER_BLOCK_PUSH_POP_DEFINES_SVH
`define BYTE_RING_BUFFER_BLOCK_PUSH_POP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BRB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/brb_pkg.sv
package brb_pkg;

   // Field widths fixed by the interface
   localparam int CNT_W  = 11;
   localparam int DATA_W = 8;

   // Defaults for the top-level parameters
   localparam int DEPTH   = 1024;
   localparam int MAX_POP = 64;

   // Size after reset, before any write to the size register
   localparam int RESET_SIZE = 1024;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_STORED = 2'd0,
      ST_REJECT = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_POPPED = 2'd3
   } status_type;

   typedef struct packed {
      logic              op;
      logic [DATA_W-1:0] data_byte;
      logic              first_of_block;
      logic [CNT_W-1:0]  length;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] out_byte;
      logic [CNT_W-1:0]  block_count;
      logic              last;
      logic [CNT_W-1:0]  free_after;
   } rsp_type;

   // Effective size after reset: the reset size, clamped to the store depth
   function automatic logic [CNT_W-1:0] reset_size(input int depth);
      logic [CNT_W-1:0] s;
      if (depth < RESET_SIZE) begin
         s = CNT_W'(depth);
      end else begin
         s = CNT_W'(RESET_SIZE);
      end
      return s;
   endfunction

endpackage

FILE: hw/rtl/byte_ring_buffer_block_push_pop.sv
// Byte ring buffer with block push and multi-byte pop. A push transaction
// returns one result; a push block is stored only if the free count covers
// the length carried on its first byte. A pop transaction of n bytes
// (n = min(request, 64-byte limit, stored)) returns n results: the store read
// is registered, then one byte leaves per cycle while rsp_ready stays high; an
// empty buffer gives one result. No request is taken while a pop run is in
// progress. Writing the size register (csr_wr_data, 0 acts as 1, above DEPTH
// acts as DEPTH) empties the buffer and drops any open block; write it only
// while the block is idle.
module byte_ring_buffer_block_push_pop #(
   parameter int DEPTH   = brb_pkg::DEPTH,
   parameter int MAX_POP = brb_pkg::MAX_POP
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  brb_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output brb_pkg::rsp_type          rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [brb_pkg::CNT_W-1:0] csr_wr_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = brb_pkg::CNT_W;

   logic [CNT_W-1:0]           eff_size_ff, eff_size_in;
   logic                       wr_en;
   logic [PTR_W-1:0]           wr_addr;
   logic [brb_pkg::DATA_W-1:0] wr_data;
   logic                       rd_en;
   logic [PTR_W-1:0]           rd_addr;
   logic [brb_pkg::DATA_W-1:0] rd_data;

   // Clamp the written size to the store depth
   always_comb begin
      if (csr_wr_data == '0) begin
         eff_size_in = CNT_W'(1);
      end else if (int'(csr_wr_data) > DEPTH) begin
         eff_size_in = CNT_W'(DEPTH);
      end else begin
         eff_size_in = csr_wr_data;
      end
   end

   // Hold the effective size
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_size_ff <= brb_pkg::reset_size(DEPTH);
      end else if (csr_wr_en) begin
         eff_size_ff <= eff_size_in;
      end
   end

   brb_ctrl #(
      .Depth  (DEPTH),
      .MaxPop (MAX_POP),
      .PtrW   (PTR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cfg_we      (csr_wr_en),
      .cfg_size    (eff_size_in),
      .eff_size    (eff_size_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   brb_store #(
      .Depth (DEPTH),
      .AddrW (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: hw/rtl/brb_store.sv
module brb_store #(
   parameter int Depth = brb_pkg::DEPTH,
   parameter int AddrW = $clog2(brb_pkg::DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AddrW-1:0]          wr_addr,
   input  logic [brb_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AddrW-1:0]          rd_addr,
   output logic [brb_pkg::DATA_W-1:0] rd_data
);

   logic [brb_pkg::DATA_W-1:0] mem_ff [Depth];
   logic [brb_pkg::DATA_W-1:0] rd_data_ff;

   // Write one byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/brb_ctrl.sv
`include "byte_ring_buffer_block_push_pop_defines.svh"

module brb_ctrl #(
   parameter int Depth  = brb_pkg::DEPTH,
   parameter int MaxPop = brb_pkg::MAX_POP,
   parameter int PtrW   = $clog2(brb_pkg::DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  brb_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output brb_pkg::rsp_type           rsp_payload,
   input  logic                       cfg_we,
   input  logic [brb_pkg::CNT_W-1:0]  cfg_size,
   input  logic [brb_pkg::CNT_W-1:0]  eff_size,
   output logic                       wr_en,
   output logic [PtrW-1:0]            wr_addr,
   output logic [brb_pkg::DATA_W-1:0] wr_data,
   output logic                       rd_en,
   output logic [PtrW-1:0]            rd_addr,
   input  logic [brb_pkg::DATA_W-1:0] rd_data
);

   localparam int CNT_W = brb_pkg::CNT_W;
   localparam int CMP_W = (PtrW + 1 > CNT_W) ? PtrW + 1 : CNT_W;
   localparam int POP_W = $clog2(MaxPop + 1);
   localparam logic [CNT_W-1:0] MAX_POP_C = CNT_W'(MaxPop);
   localparam logic [CNT_W-1:0] SIZE_RST  = brb_pkg::reset_size(Depth);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_POP  = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [PtrW-1:0]        rptr_ff, rptr_in;
   logic [PtrW-1:0]        wptr_ff, wptr_in;
   logic [CNT_W-1:0]       free_ff, free_in;
   logic [CNT_W-1:0]       brem_ff, brem_in;
   logic                   bacc_ff, bacc_in;
   logic [POP_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]       popn_ff, popn_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   brb_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   slot_free;
   logic                   accept;
   logic                   is_push;
   logic [CNT_W-1:0]       len1;
   logic [CNT_W-1:0]       stored;
   logic [CNT_W-1:0]       n_lim;
   logic [CNT_W-1:0]       pop_n;
   logic                   open_new;
   logic                   blk_acc;
   logic [CNT_W-1:0]       blk_len;
   logic [CNT_W-1:0]       push_count;

   // Step a pointer, wrapping at the effective size
   function automatic logic [PtrW-1:0] adv(input logic [PtrW-1:0] p,
                                           input logic [CNT_W-1:0] s);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(p) + CMP_W'(1);
      return (nxt >= CMP_W'(s)) ? '0 : nxt[PtrW-1:0];
   endfunction

   // Handshake: take a transaction only when idle and the output slot frees
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign is_push   = (req_payload.op == brb_pkg::OP_PUSH);

   // Decode the request
   always_comb begin
      len1   = (req_payload.length == '0) ? CNT_W'(1) : req_payload.length;
      stored = (free_ff <= eff_size) ? eff_size - free_ff : '0;
      n_lim  = (len1 > MAX_POP_C) ? MAX_POP_C : len1;
      pop_n  = (n_lim > stored) ? stored : n_lim;

      open_new = req_payload.first_of_block || (brem_ff == '0);
      if (open_new) begin
         blk_acc    = (free_ff >= len1);
         blk_len    = len1;
         push_count = blk_acc ? (req_payload.first_of_block ? len1 : CNT_W'(1)) : '0;
      end else begin
         blk_acc    = bacc_ff;
         blk_len    = brem_ff;
         push_count = '0;
      end
   end

   // Store port
   assign wr_en   = accept && is_push && blk_acc && (free_ff != '0);
   assign wr_addr = wptr_ff;
   assign wr_data = req_payload.data_byte;

   // Fetch port: first byte at accept, the rest as each byte leaves
   assign rd_en   = (accept && !is_push && (stored != '0)) ||
                    ((state_ff == S_POP) && slot_free && (rem_ff > POP_W'(1)));
   assign rd_addr = rptr_ff;

   // Next state
   always_comb begin
      state_in     = state_ff;
      rptr_in      = rd_en ? adv(rptr_ff, eff_size) : rptr_ff;
      wptr_in      = wr_en ? adv(wptr_ff, eff_size) : wptr_ff;
      free_in      = free_ff;
      brem_in      = brem_ff;
      bacc_in      = bacc_ff;
      rem_in       = rem_ff;
      popn_in      = popn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (accept && is_push) begin
         // Push: one result, store when the block fits
         brem_in               = blk_len - CNT_W'(1);
         bacc_in               = blk_acc;
         rsp_valid_in          = 1'b1;
         rsp_in.out_byte       = '0;
         rsp_in.last           = 1'b1;
         if (wr_en) begin
            free_in            = free_ff - CNT_W'(1);
            rsp_in.status      = brb_pkg::ST_STORED;
            rsp_in.block_count = push_count;
            rsp_in.free_after  = free_ff - CNT_W'(1);
         end else begin
            rsp_in.status      = brb_pkg::ST_REJECT;
            rsp_in.block_count = '0;
            rsp_in.free_after  = free_ff;
         end
      end else if (accept) begin
         // Pop: report empty at once, else start the byte run
         if (stored == '0) begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = brb_pkg::ST_EMPTY;
            rsp_in.out_byte    = '0;
            rsp_in.block_count = '0;
            rsp_in.last        = 1'b1;
            rsp_in.free_after  = free_ff;
         end else begin
            rem_in   = POP_W'(pop_n);
            popn_in  = pop_n;
            state_in = S_POP;
         end
      end else if ((state_ff == S_POP) && slot_free) begin
         // Hand the fetched byte to the output register
         free_in            = free_ff + CNT_W'(1);
         rem_in             = rem_ff - POP_W'(1);
         rsp_valid_in       = 1'b1;
         rsp_in.status      = brb_pkg::ST_POPPED;
         rsp_in.out_byte    = rd_data;
         rsp_in.block_count = popn_ff;
         rsp_in.last        = (rem_ff == POP_W'(1));
         rsp_in.free_after  = free_ff + CNT_W'(1);
         if (rem_ff == POP_W'(1)) begin
            state_in = S_IDLE;
         end
      end

      // Size write: restart the buffer
      if (cfg_we) begin
         rptr_in = '0;
         wptr_in = '0;
         free_in = cfg_size;
         brem_in = '0;
         bacc_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         free_ff      <= SIZE_RST;
         brem_ff      <= '0;
         bacc_ff      <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         free_ff      <= free_in;
         brem_ff      <= brem_in;
         bacc_ff      <= bacc_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      popn_ff <= popn_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `BRB_ASSERT_IMP(a_free_in_range, clock, reset, 1'b1, free_ff <= eff_size, "free count above size")
   `BRB_ASSERT_IMP(a_pop_has_bytes, clock, reset, state_ff == S_POP, rem_ff != '0, "pop run with no bytes left")
   `BRB_ASSERT_IMP(a_fetch_slot, clock, reset, rd_en, slot_free, "fetch would overwrite a pending byte")
   `BRB_ASSERT_IMP(a_write_room, clock, reset, wr_en, (free_ff != '0) && (state_ff == S_IDLE), "store write without room")

endmodule

FILE: dv/byte_ring_buffer_block_push_pop_tb.sv
module byte_ring_buffer_block_push_pop_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CNT_W   = brb_pkg::CNT_W;
   localparam int DEPTH   = brb_pkg::DEPTH;
   localparam int MAX_POP = brb_pkg::MAX_POP;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      brb_pkg::req_type req;
      logic [CNT_W-1:0] cfg;
      logic             typed;
      brb_pkg::rsp_type want;
   } plan_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   brb_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   brb_pkg::rsp_type rsp_payload;
   logic             csr_wr_en   = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   // Typed expectation travelling alongside the request payload
   logic             fixed_due   = 1'b0;
   brb_pkg::rsp_type fixed_rsp   = '0;

   // Shadow copy of the ring state
   logic [7:0]       ring_bytes [DEPTH];
   logic [CNT_W-1:0] ring_size;
   int               rd_ptr, wr_ptr, ring_free, blk_left;
   logic             blk_ok;
   brb_pkg::rsp_type ring_results_due [$];

   int               faults = 0;
   logic             calm   = 1'b0;
   plan_row_type     plan [$];

   byte_ring_buffer_block_push_pop uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none at all while calm
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic brb_pkg::req_type mk_req(input logic op, input logic [7:0] data,
                                               input logic first,
                                               input logic [CNT_W-1:0] len);
      brb_pkg::req_type r;
      r.op             = op;
      r.data_byte      = data;
      r.first_of_block = first;
      r.length         = len;
      return r;
   endfunction

   function automatic brb_pkg::rsp_type mk_rsp(input brb_pkg::status_type st,
                                               input logic [7:0] b,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic last,
                                               input logic [CNT_W-1:0] freec);
      brb_pkg::rsp_type s;
      s.status      = st;
      s.out_byte    = b;
      s.block_count = cnt;
      s.last        = last;
      s.free_after  = freec;
      return s;
   endfunction

   function automatic plan_row_type do_req(input brb_pkg::req_type r);
      plan_row_type p;
      p.kind  = ROW_REQ;
      p.req   = r;
      p.cfg   = '0;
      p.typed = 1'b0;
      p.want  = '0;
      return p;
   endfunction

   function automatic plan_row_type do_chk(input brb_pkg::req_type r,
                                           input brb_pkg::rsp_type want);
      plan_row_type p;
      p       = do_req(r);
      p.typed = 1'b1;
      p.want  = want;
      return p;
   endfunction

   function automatic plan_row_type do_cfg(input logic [CNT_W-1:0] v);
      plan_row_type p;
      p     = do_req('0);
      p.kind = ROW_CFG;
      p.cfg  = v;
      return p;
   endfunction

   // Slots in use: zero acts as one, above the store depth acts as the depth
   function automatic int ring_span();
      if (ring_size == 0) return 1;
      if (ring_size > DEPTH) return DEPTH;
      return int'(ring_size);
   endfunction

   function automatic int ring_next(input int p);
      return (p + 1 >= ring_span()) ? 0 : p + 1;
   endfunction

   function automatic void ring_clear();
      rd_ptr    = 0;
      wr_ptr    = 0;
      ring_free = ring_span();
      blk_left  = 0;
      blk_ok    = 1'b0;
   endfunction

   // Apply one request to the shadow ring and return the results it causes
   task automatic ring_apply(input brb_pkg::req_type r, output brb_pkg::rsp_type res [$]);
      int               len, cnt, n, held;
      brb_pkg::rsp_type one;
      res = {};
      len = (r.length == 0) ? 1 : int'(r.length);
      if (r.op == brb_pkg::OP_PUSH) begin
         cnt = 0;
         // A first byte, or a stray byte with no open block, opens a block
         if (r.first_of_block || blk_left == 0) begin
            blk_ok   = (ring_free >= len);
            blk_left = len;
            if (blk_ok) cnt = r.first_of_block ? len : 1;
         end
         blk_left--;
         if (blk_ok && ring_free > 0) begin
            ring_bytes[wr_ptr] = r.data_byte;
            wr_ptr = ring_next(wr_ptr);
            ring_free--;
            one = mk_rsp(brb_pkg::ST_STORED, 8'h00, CNT_W'(cnt), 1'b1,
                         CNT_W'(ring_free));
         end else begin
            one = mk_rsp(brb_pkg::ST_REJECT, 8'h00, '0, 1'b1, CNT_W'(ring_free));
         end
         res.push_back(one);
      end else begin
         held = ring_span() - ring_free;
         n    = (len > MAX_POP) ? MAX_POP : len;
         if (held == 0) begin
            res.push_back(mk_rsp(brb_pkg::ST_EMPTY, 8'h00, '0, 1'b1, CNT_W'(ring_free)));
         end else begin
            if (n > held) n = held;
            for (int i = 0; i < n; i++) begin
               one = mk_rsp(brb_pkg::ST_POPPED, ring_bytes[rd_ptr], CNT_W'(n),
                            i + 1 == n, '0);
               rd_ptr = ring_next(rd_ptr);
               ring_free++;
               one.free_after = CNT_W'(ring_free);
               res.push_back(one);
            end
         end
      end
   endtask

   function automatic void check_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         faults++;
      end
   endfunction

   // Track every transaction on both channels and the size register
   always @(posedge clock) begin
      brb_pkg::rsp_type made [$];
      brb_pkg::rsp_type want;
      if (reset) begin
         ring_size = CNT_W'(brb_pkg::RESET_SIZE);
         ring_clear();
         ring_results_due.delete();
      end else begin
         if (csr_wr_en) begin
            ring_size = csr_wr_data;
            ring_clear();
         end
         if (req_valid && req_ready) begin
            ring_apply(req_payload, made);
            if (fixed_due) ring_results_due.push_back(fixed_rsp);
            else foreach (made[i]) ring_results_due.push_back(made[i]);
         end
         if (rsp_valid && rsp_ready) begin
            if (ring_results_due.size() == 0) begin
               $display("%0t: result expected none, got %h", $time, rsp_payload);
               faults++;
            end else begin
               want = ring_results_due.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_payload.status));
               check_field("out_byte", 16'(want.out_byte), 16'(rsp_payload.out_byte));
               check_field("block_count", 16'(want.block_count),
                           16'(rsp_payload.block_count));
               check_field("last", 16'(want.last), 16'(rsp_payload.last));
               check_field("free_after", 16'(want.free_after),
                           16'(rsp_payload.free_after));
            end
         end
      end
   end

   // Stall the result channel at random
   always begin
      int unsigned stall;
      @(posedge clock);
      stall = pick_gap();
      if (stall == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
         rsp_ready <= 1'b1;
      end
   end

   // Hold the request until accepted, then idle for a random gap
   task automatic send_req(input brb_pkg::req_type r, input logic typed,
                           input brb_pkg::rsp_type want);
      int unsigned gap;
      req_payload <= r;
      req_valid   <= 1'b1;
      fixed_due   <= typed;
      fixed_rsp   <= want;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ring_results_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_size(input logic [CNT_W-1:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Push a block header and nbytes bytes in all; fewer than len breaks it off
   task automatic send_block(input int unsigned len, input int unsigned nbytes);
      send_req(mk_req(brb_pkg::OP_PUSH, 8'($urandom_range(0, 255)), 1'b1, CNT_W'(len)),
               1'b0, '0);
      for (int unsigned k = 1; k < nbytes; k++)
         send_req(mk_req(brb_pkg::OP_PUSH, 8'($urandom_range(0, 255)), 1'b0,
                         CNT_W'($urandom_range(0, 2047))), 1'b0, '0);
   endtask

   initial begin
      int unsigned sel, len, nbytes, sz;
      int          made;

      // Directed transactions: empty, extremes, block abandon, stray byte, wrap
      plan.push_back(do_chk(mk_req(brb_pkg::OP_POP, 8'h00, 1'b0, 11'd5),
                            mk_rsp(brb_pkg::ST_EMPTY, 8'h00, 11'd0, 1'b1, 11'd1024)));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_PUSH, 8'hFF, 1'b1, 11'd0),
                            mk_rsp(brb_pkg::ST_STORED, 8'h00, 11'd1, 1'b1, 11'd1023)));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_PUSH, 8'h00, 1'b1, 11'd2047),
                            mk_rsp(brb_pkg::ST_REJECT, 8'h00, 11'd0, 1'b1, 11'd1023)));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_PUSH, 8'hAA, 1'b0, 11'd0),
                            mk_rsp(brb_pkg::ST_REJECT, 8'h00, 11'd0, 1'b1, 11'd1023)));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_PUSH, 8'h00, 1'b1, 11'd3),
                            mk_rsp(brb_pkg::ST_STORED, 8'h00, 11'd3, 1'b1, 11'd1022)));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_PUSH, 8'h55, 1'b0, 11'd0),
                            mk_rsp(brb_pkg::ST_STORED, 8'h00, 11'd0, 1'b1, 11'd1021)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'h81, 1'b1, 11'd2)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'h7E, 1'b0, 11'd0)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'h12, 1'b0, 11'd5)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_POP, 8'hFF, 1'b1, 11'd0)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_POP, 8'h00, 1'b0, 11'd2047)));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_POP, 8'h00, 1'b0, 11'd64),
                            mk_rsp(brb_pkg::ST_EMPTY, 8'h00, 11'd0, 1'b1, 11'd1024)));
      plan.push_back(do_cfg(11'd0));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_PUSH, 8'h3C, 1'b1, 11'd1),
                            mk_rsp(brb_pkg::ST_STORED, 8'h00, 11'd1, 1'b1, 11'd0)));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_PUSH, 8'hC3, 1'b1, 11'd1),
                            mk_rsp(brb_pkg::ST_REJECT, 8'h00, 11'd0, 1'b1, 11'd0)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_POP, 8'h00, 1'b0, 11'd64)));
      plan.push_back(do_cfg(11'd3));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'hA1, 1'b1, 11'd3)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'hB2, 1'b0, 11'd0)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'hC3, 1'b0, 11'd0)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_POP, 8'h00, 1'b0, 11'd2)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'hD4, 1'b1, 11'd2)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_PUSH, 8'hE5, 1'b0, 11'd0)));
      plan.push_back(do_req(mk_req(brb_pkg::OP_POP, 8'h00, 1'b0, 11'd64)));
      plan.push_back(do_cfg(11'd2047));
      plan.push_back(do_chk(mk_req(brb_pkg::OP_POP, 8'h00, 1'b0, 11'd1),
                            mk_rsp(brb_pkg::ST_EMPTY, 8'h00, 11'd0, 1'b1, 11'd1024)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) write_size(plan[i].cfg);
         else send_req(plan[i].req, plan[i].typed, plan[i].want);
      end

      // Random phases, each under its own ring size
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       sz = 2047;
            1:       sz = 1;
            2:       sz = $urandom_range(2, 8);
            3:       sz = 1024;
            4:       sz = $urandom_range(9, 70);
            default: sz = $urandom_range(0, 1024);
         endcase
         calm = (ph == 3);
         write_size(CNT_W'(sz));
         made = 0;
         while (made < 26) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
               // Well-formed block, mostly short
               sel = $urandom_range(0, 9);
               len = (sel < 7) ? $urandom_range(1, 6) : $urandom_range(0, 24);
               nbytes = (len == 0) ? 1 : len;
               send_block(len, nbytes);
               made += nbytes;
            end else if (sel < 80) begin
               sel = $urandom_range(0, 9);
               len = (sel < 7) ? $urandom_range(1, 16) : $urandom_range(0, 2047);
               send_req(mk_req(brb_pkg::OP_POP, 8'($urandom_range(0, 255)), 1'($urandom),
                               CNT_W'(len)), 1'b0, '0);
               made++;
            end else if (sel < 90) begin
               // Stray byte with no block header
               send_req(mk_req(brb_pkg::OP_PUSH, 8'($urandom_range(0, 255)), 1'b0,
                               CNT_W'($urandom_range(0, 2047))), 1'b0, '0);
               made++;
            end else begin
               // Block broken off early, often far too long to fit
               len = $urandom_range(0, 2047);
               nbytes = $urandom_range(1, 3);
               send_block(len, nbytes);
               made += nbytes;
            end
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (faults == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Drop the run if it hangs
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
